@@ design/u8sd_pkg.sv @@
// Package for the UTF-8 stream decoder: widths, lead-byte constants, shared types.
// Depends on nothing; every other design file depends on it.
package u8sd_pkg;

  localparam int BYTE_W      = 8;
  localparam int CP_W        = 26;
  localparam int OUT_COUNT_W = 16;
  localparam int REM_W       = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int LIMIT_W     = 16;

  // Register byte addresses.
  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_CHARS = 3'd0;

  // Lead-byte classification masks and patterns.
  localparam logic [7:0] ASCII_MASK  = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_PAT   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_PAT   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_PAT   = 8'hF0;
  localparam logic [7:0] CONT_MASK   = 8'h3F;
  localparam logic [7:0] LEAD2_BITS  = 8'h1F;
  localparam logic [7:0] LEAD3_BITS  = 8'h0F;
  localparam logic [7:0] LEAD4_BITS  = 8'h07;
  localparam logic [7:0] LEAD5_BITS  = 8'h03;

  localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;
  } u8sd_item_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;     // following bytes the lead byte announces
    logic [CP_W-1:0]  value;   // lead bits already placed in the code point
  } u8sd_lead_t;

  typedef struct packed {
    logic [CP_W-1:0]        code_point;
    logic                   char_valid;
    logic                   string_done;
    logic                   truncated;
    logic [OUT_COUNT_W-1:0] char_count;
  } u8sd_result_t;

  // Places a group of payload bits at six-bit slot pos of the code point.
  // Bits that land above the code point width are dropped.
  function automatic logic [CP_W-1:0] place_sextet(input logic [BYTE_W-1:0] val,
                                                   input logic [REM_W-1:0] pos);
    logic [CP_W-1:0] w;
    w = CP_W'(val);
    unique case (pos)
      3'd0:    return w;
      3'd1:    return w << 6;
      3'd2:    return w << 12;
      3'd3:    return w << 18;
      3'd4:    return w << 24;
      default: return '0;
    endcase
  endfunction

endpackage

@@ design/u8sd_ifs.sv @@
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on u8sd_pkg for the field widths.
interface u8sd_in_if;
  logic                          valid;
  logic                          ready;
  logic [u8sd_pkg::BYTE_W-1:0]   data_byte;
  logic                          end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u8sd_out_if;
  logic                              valid;
  logic                              ready;
  logic [u8sd_pkg::CP_W-1:0]         code_point;
  logic                              char_valid;
  logic                              string_done;
  logic                              truncated;
  logic [u8sd_pkg::OUT_COUNT_W-1:0]  char_count;

  modport source (output valid, output code_point, output char_valid, output string_done,
                  output truncated, output char_count, input ready);
  modport sink   (input valid, input code_point, input char_valid, input string_done,
                  input truncated, input char_count, output ready);
endinterface

@@ design/u8sd_lead_dec.sv @@
// Lead-byte decoder: sequence length and the lead's payload bits, already placed.
// Depends on u8sd_pkg.
module u8sd_lead_dec (
  input  logic [u8sd_pkg::BYTE_W-1:0] data_byte,
  output u8sd_pkg::u8sd_lead_t        lead
);
  import u8sd_pkg::*;

  logic [BYTE_W-1:0] bits;

  always_comb begin
    if ((data_byte & ASCII_MASK) == 8'h00) begin
      lead.rem = 3'd0;
      bits     = data_byte;
    end else if ((data_byte & LEAD2_MASK) == LEAD2_PAT) begin
      lead.rem = 3'd1;
      bits     = data_byte & LEAD2_BITS;
    end else if ((data_byte & LEAD3_MASK) == LEAD3_PAT) begin
      lead.rem = 3'd2;
      bits     = data_byte & LEAD3_BITS;
    end else if ((data_byte & LEAD4_MASK) == LEAD4_PAT) begin
      lead.rem = 3'd3;
      bits     = data_byte & LEAD4_BITS;
    end else begin
      // Anything else opens a five-byte sequence; only two lead bits fit.
      lead.rem = 3'd4;
      bits     = data_byte & LEAD5_BITS;
    end
    lead.value = place_sextet(bits, lead.rem);
  end

endmodule

@@ design/u8sd_step.sv @@
// Per-string decode state and the combinational step that consumes one byte.
// Depends on u8sd_pkg and u8sd_lead_dec.
module u8sd_step #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  u8sd_pkg::u8sd_item_t              item,
  input  logic [u8sd_pkg::LIMIT_W-1:0]      max_chars,
  output logic                              emit,
  output u8sd_pkg::u8sd_result_t            result
);
  import u8sd_pkg::*;

  localparam int CMP_W = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [CP_W-1:0]       part_r, part_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  lim_r, lim_nxt;
  logic                  done;
  logic                  limit_hit;
  logic [CMP_W-1:0]      cnt_wide;
  u8sd_lead_t            lead;

  u8sd_lead_dec u_lead (
    .data_byte (item.data_byte),
    .lead      (lead)
  );

  assign limit_hit = (max_chars != '0) && (CMP_W'(cnt_r) >= CMP_W'(max_chars));

  always_comb begin
    rem_nxt  = rem_r;
    part_nxt = part_r;
    cnt_nxt  = cnt_r;
    lim_nxt  = lim_r;
    done     = 1'b0;
    result   = '0;

    if (rem_r == '0) begin
      // A lead byte is due; the limit is checked only here.
      lim_nxt = lim_r | limit_hit;
      if (!lim_nxt) begin
        rem_nxt  = lead.rem;
        part_nxt = lead.value;
        done     = (lead.rem == '0);
      end
    end else begin
      rem_nxt  = rem_r - 3'd1;
      part_nxt = part_r | place_sextet(item.data_byte & CONT_MASK, rem_nxt);
      done     = (rem_nxt == '0);
    end

    if (done) begin
      result.code_point = part_nxt;
      part_nxt          = '0;
      if (cnt_r != COUNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end

    cnt_wide           = CMP_W'(cnt_nxt);
    result.char_valid  = done;
    result.string_done = item.end_of_string;
    result.truncated   = item.end_of_string && (rem_nxt != '0);
    result.char_count  = (cnt_wide > CMP_W'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX
                                                             : cnt_wide[OUT_COUNT_W-1:0];
    emit = done | item.end_of_string;

    // The end byte starts the next string from a clean state.
    if (item.end_of_string) begin
      rem_nxt  = '0;
      part_nxt = '0;
      cnt_nxt  = '0;
      lim_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      part_r <= '0;
      cnt_r  <= '0;
      lim_r  <= 1'b0;
    end else if (advance) begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
      cnt_r  <= cnt_nxt;
      lim_r  <= lim_nxt;
    end
  end

endmodule

@@ design/utf8_stream_decoder.sv @@
// UTF-8 stream decoder top level: input register, decode step, result register.
// A word passes from the input register through the combinational decode step
// into the result register, where the sink takes it.
// Throughput: one byte per cycle unless a result waits for the sink.
// Synchronous active-low reset clears all control and decode state and max_chars.
// Depends on u8sd_pkg, u8sd_ifs, u8sd_lead_dec and u8sd_step.
module utf8_stream_decoder #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  u8sd_in_if.sink                             in_ch,
  u8sd_out_if.source                          out_ch,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [u8sd_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [u8sd_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [u8sd_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import u8sd_pkg::*;

  // Configuration register. Only the word-select bit of the address is
  // decoded, so the byte offsets within the word alias onto it.
  logic [LIMIT_W-1:0] max_chars_r;
  logic               cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = (cfg_paddr[CFG_ADDR_W-1] == ADDR_MAX_CHARS[CFG_ADDR_W-1]);
  assign cfg_prdata = cfg_sel ? CFG_DATA_W'(max_chars_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel) begin
      max_chars_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  // Input register. It holds one word; the word moves on as soon as the
  // decode step can place its result (or has none to place), so a new word
  // can be taken in the same cycle.
  logic         in_v_r;
  u8sd_item_t   in_item_r;
  logic         step_go;
  logic         step_emit;
  u8sd_result_t step_result;

  // Result register, freed in the same cycle that the sink takes it.
  logic         out_v_r;
  u8sd_result_t out_res_r;
  logic         out_free;

  assign out_free    = !out_v_r || out_ch.ready;
  assign step_go     = in_v_r && (!step_emit || out_free);
  assign in_ch.ready = !in_v_r || step_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.data_byte     <= in_ch.data_byte;
      in_item_r.end_of_string <= in_ch.end_of_string;
    end
  end

  // Decode step: lead-byte decode, accumulation, count and limit handling.
  u8sd_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (step_go),
    .item      (in_item_r),
    .max_chars (max_chars_r),
    .emit      (step_emit),
    .result    (step_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= step_go && step_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step_go && step_emit) begin
      out_res_r <= step_result;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.code_point  = out_res_r.code_point;
  assign out_ch.char_valid  = out_res_r.char_valid;
  assign out_ch.string_done = out_res_r.string_done;
  assign out_ch.truncated   = out_res_r.truncated;
  assign out_ch.char_count  = out_res_r.char_count;

endmodule
